[rtl/mmscp_pkg.sv]
package mmscp_pkg;

  localparam int unsigned WordW = 9;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ServoW = 11;
  localparam int unsigned MotorW = 9;

  localparam logic [ByteW-1:0] CmdMotorSpeed = 8'd10;
  localparam logic [ByteW-1:0] CmdServoAngle = 8'd11;
  localparam logic [ByteW-1:0] CmdMotorInv = 8'd12;
  localparam logic [ByteW-1:0] CmdServoInv = 8'd13;
  localparam logic [ByteW-1:0] CmdServoTrim = 8'd14;

  localparam logic [ServoW-1:0] ServoMax = 11'd1799;
  localparam logic [ServoW-1:0] ServoCentreRst = 11'd900;
  localparam logic [ServoW-1:0] ServoBase = 11'd1000;
  localparam logic [7:0] MotorMax = 8'd100;
  // round(65536 * 1000 / 1800), exact floor over 0..1799
  localparam logic [15:0] ServoScale = 16'd36409;

  typedef enum logic [2:0] {
    StNothing = 3'd0,
    StMatched = 3'd1,
    StIgnored = 3'd2,
    StUnknown = 3'd3,
    StBadSum = 3'd4,
    StApplied = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhCommand = 4'b0010,
    PhPayload = 4'b0100,
    PhCheck = 4'b1000
  } phase_e;

  // packed lowest field last so the struct maps onto tdata from bit 0 up
  typedef struct packed {
    logic motor_forward;
    logic [MotorW-1:0] motor_compare;
    logic motor_update;
    logic [ServoW-1:0] servo_compare;
    logic servo_update;
    logic led_toggle;
    status_e status;
  } result_t;

  typedef struct packed {
    logic servo_update;
    logic [ServoW-1:0] servo_compare;
    logic motor_update;
    logic [MotorW-1:0] motor_compare;
    logic motor_forward;
    logic [ServoW-1:0] trim;
  } apply_t;

endpackage

[rtl/mmscp_apply.sv]
module mmscp_apply (
  input  logic [7:0]                    cmd_i,
  input  logic [7:0]                    p0_i,
  input  logic [7:0]                    p1_i,
  input  logic                          motor_inv_i,
  input  logic                          servo_inv_i,
  input  logic [mmscp_pkg::ServoW-1:0]  centre_i,
  output mmscp_pkg::apply_t             apply_o
);

  logic signed [15:0] angle_raw;
  logic signed [17:0] angle_v;
  logic [mmscp_pkg::ServoW-1:0] angle_c;
  logic [26:0] angle_prod;
  logic signed [7:0] speed;
  logic [7:0] speed_mag;
  logic [7:0] speed_c;
  logic [15:0] trim_raw;

  always_comb begin
    angle_raw = $signed({p1_i, p0_i});
    if (servo_inv_i) begin
      angle_v = -18'(angle_raw);
    end else begin
      angle_v = 18'(angle_raw);
    end
    angle_v = angle_v + $signed({7'd0, centre_i});
    if (angle_v >= 18'sd1800) begin
      angle_c = mmscp_pkg::ServoMax;
    end else if (angle_v < 18'sd0) begin
      angle_c = '0;
    end else begin
      angle_c = angle_v[mmscp_pkg::ServoW-1:0];
    end
    angle_prod = 27'(angle_c) * 27'(mmscp_pkg::ServoScale);

    speed = $signed(p0_i);
    speed_mag = speed[7] ? 8'(-speed) : p0_i;
    speed_c = (speed_mag > mmscp_pkg::MotorMax) ? mmscp_pkg::MotorMax : speed_mag;

    trim_raw = {p1_i, p0_i};

    apply_o = '0;
    case (cmd_i)
      mmscp_pkg::CmdServoAngle: begin
        apply_o.servo_update = 1'b1;
        apply_o.servo_compare = mmscp_pkg::ServoBase + angle_prod[26:16];
      end
      mmscp_pkg::CmdMotorSpeed: begin
        apply_o.motor_update = 1'b1;
        apply_o.motor_compare = {speed_c[6:0], 2'b00};
        apply_o.motor_forward = ~speed[7] ^ motor_inv_i;
      end
      mmscp_pkg::CmdServoTrim: begin
        if (trim_raw >= 16'd1800) begin
          apply_o.trim = mmscp_pkg::ServoMax;
        end else begin
          apply_o.trim = trim_raw[mmscp_pkg::ServoW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/multidrop_motor_servo_command_parser.sv]
// An accepted word is held in the input register, its status in the result register.
// One word per cycle while m_axis does not stall; the two registers decouple the two
// sides, the parse and apply logic sits between them.
// Reset (rst_ni low, asynchronous): parser idle, checksum, command and counts
// cleared, invert flags off, trim 900, node mask 1, both stages empty.
module multidrop_motor_servo_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [8:0] rx_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [2:0] status, [3] led_toggle, [4] servo_update,
                                     // [15:5] servo_compare, [16] motor_update,
                                     // [25:17] motor_compare, [26] motor_forward
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] mask_q;
  logic in_valid_q;
  logic [mmscp_pkg::WordW-1:0] in_word_q;
  logic out_valid_q;
  mmscp_pkg::result_t out_q, res_d;
  logic adv;

  mmscp_pkg::phase_e phase_q, phase_d;
  logic [7:0] csum_q, csum_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] pay_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] exp_q, exp_d;
  logic motor_inv_q, motor_inv_d;
  logic servo_inv_q, servo_inv_d;
  logic [mmscp_pkg::ServoW-1:0] centre_q, centre_d;
  logic pay_we;
  logic [7:0] data;
  logic [7:0] sum;
  mmscp_pkg::apply_t app;

  assign adv = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {5'd0, out_q};

  assign data = in_word_q[7:0];
  assign sum = csum_q ^ data;

  mmscp_apply u_apply (
    .cmd_i       (cmd_q),
    .p0_i        (pay_q[0]),
    .p1_i        (pay_q[1]),
    .motor_inv_i (motor_inv_q),
    .servo_inv_i (servo_inv_q),
    .centre_i    (centre_q),
    .apply_o     (app)
  );

  always_comb begin
    phase_d = phase_q;
    csum_d = csum_q;
    cmd_d = cmd_q;
    cnt_d = cnt_q;
    exp_d = exp_q;
    motor_inv_d = motor_inv_q;
    servo_inv_d = servo_inv_q;
    centre_d = centre_q;
    pay_we = 1'b0;
    res_d = '0;
    res_d.status = mmscp_pkg::StNothing;
    if (in_word_q[8]) begin
      if ((data & mask_q) != 8'd0) begin
        phase_d = mmscp_pkg::PhCommand;
        res_d.status = mmscp_pkg::StMatched;
        res_d.led_toggle = 1'b1;
      end else begin
        phase_d = mmscp_pkg::PhIdle;
        res_d.status = mmscp_pkg::StIgnored;
      end
    end else begin
      case (phase_q)
        mmscp_pkg::PhCommand: begin
          csum_d = data;
          cmd_d = data;
          cnt_d = 2'd0;
          if (data inside {mmscp_pkg::CmdServoAngle, mmscp_pkg::CmdServoTrim}) begin
            exp_d = 2'd2;
            phase_d = mmscp_pkg::PhPayload;
          end else if (data inside {mmscp_pkg::CmdMotorSpeed, mmscp_pkg::CmdMotorInv,
                                    mmscp_pkg::CmdServoInv}) begin
            exp_d = 2'd1;
            phase_d = mmscp_pkg::PhPayload;
          end else begin
            exp_d = 2'd0;
            phase_d = mmscp_pkg::PhIdle;
            res_d.status = mmscp_pkg::StUnknown;
          end
        end
        mmscp_pkg::PhPayload: begin
          csum_d = sum;
          pay_we = 1'b1;
          cnt_d = cnt_q + 2'd1;
          if (cnt_d >= exp_q) begin
            phase_d = mmscp_pkg::PhCheck;
          end
        end
        mmscp_pkg::PhCheck: begin
          csum_d = sum;
          phase_d = mmscp_pkg::PhIdle;
          if (sum != 8'd0) begin
            res_d.status = mmscp_pkg::StBadSum;
          end else begin
            res_d.status = mmscp_pkg::StApplied;
            res_d.servo_update = app.servo_update;
            res_d.servo_compare = app.servo_compare;
            res_d.motor_update = app.motor_update;
            res_d.motor_compare = app.motor_compare;
            res_d.motor_forward = app.motor_forward;
            case (cmd_q)
              mmscp_pkg::CmdMotorInv: motor_inv_d = (pay_q[0] != 8'd0);
              mmscp_pkg::CmdServoInv: servo_inv_d = (pay_q[0] != 8'd0);
              mmscp_pkg::CmdServoTrim: centre_d = app.trim;
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 8'd1;
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q <= mmscp_pkg::PhIdle;
      csum_q <= '0;
      cmd_q <= '0;
      cnt_q <= '0;
      exp_q <= '0;
      motor_inv_q <= 1'b0;
      servo_inv_q <= 1'b0;
      centre_q <= mmscp_pkg::ServoCentreRst;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        phase_q <= phase_d;
        csum_q <= csum_d;
        cmd_q <= cmd_d;
        cnt_q <= cnt_d;
        exp_q <= exp_d;
        motor_inv_q <= motor_inv_d;
        servo_inv_q <= servo_inv_d;
        centre_q <= centre_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata[mmscp_pkg::WordW-1:0];
    end
    if (adv) begin
      out_q <= res_d;
    end
    if (adv && pay_we) begin
      pay_q[cnt_q[0]] <= data;
    end
  end

`ifndef NO_ASSERTIONS
  a_led_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.led_toggle |-> out_q.status == mmscp_pkg::StMatched)
    else $error("led toggle without matched address");

  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.servo_update |->
      out_q.status == mmscp_pkg::StApplied && out_q.servo_compare >= 11'd1000 &&
      out_q.servo_compare <= 11'd1999)
    else $error("servo compare out of range");

  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.motor_update |->
      out_q.status == mmscp_pkg::StApplied && out_q.motor_compare <= 9'd400)
    else $error("motor compare out of range");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_word_q))
    else $error("stalled input stage lost its request");
`endif

endmodule

[tb/sv/tb_multidrop_motor_servo_command_parser.sv]
`timescale 1ns / 100ps

module tb_multidrop_motor_servo_command_parser;

  typedef struct packed {
    logic [mmscp_pkg::WordW-1:0] word;
    logic                        typed;
    mmscp_pkg::result_t          want;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  multidrop_motor_servo_command_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // parser model state
  logic [mmscp_pkg::ByteW-1:0]  pr_mask = 8'd1;
  mmscp_pkg::phase_e            pr_phase = mmscp_pkg::PhIdle;
  logic [mmscp_pkg::ByteW-1:0]  pr_sum = '0;
  logic [mmscp_pkg::ByteW-1:0]  pr_cmd = '0;
  logic [mmscp_pkg::ByteW-1:0]  pr_pay [2];
  logic [1:0]                   pr_cnt = '0;
  logic [1:0]                   pr_need = '0;
  logic                         pr_motor_inv = 1'b0;
  logic                         pr_servo_inv = 1'b0;
  logic [mmscp_pkg::ServoW-1:0] pr_trim = mmscp_pkg::ServoCentreRst;

  mmscp_pkg::result_t owed_status_q [$];
  probe_t      probes [$];
  int unsigned n_errors = 0;
  int unsigned n_words = 0;
  int unsigned n_results = 0;
  int unsigned n_motor = 0;
  int unsigned n_servo = 0;
  int unsigned n_settings = 0;
  int unsigned n_badsum = 0;
  int unsigned n_unknown = 0;
  int unsigned n_matched = 0;
  int unsigned n_masks = 0;
  bit          src_burst = 1'b0;
  bit          snk_burst = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(4_000_000);
    $display("timeout: %0d requests still owed a status", owed_status_q.size());
    $display("** multidrop_motor_servo_command_parser: FAILED **");
    $finish;
  end

  function automatic mmscp_pkg::result_t parse_word(input logic [mmscp_pkg::WordW-1:0] w);
    mmscp_pkg::result_t          r;
    logic [mmscp_pkg::ByteW-1:0] d;
    int                          v;
    r = '0;
    d = w[mmscp_pkg::ByteW-1:0];
    if (w[mmscp_pkg::WordW-1]) begin
      if ((d & pr_mask) != '0) begin
        pr_phase = mmscp_pkg::PhCommand;
        r.status = mmscp_pkg::StMatched;
        r.led_toggle = 1'b1;
      end else begin
        pr_phase = mmscp_pkg::PhIdle;
        r.status = mmscp_pkg::StIgnored;
      end
      return r;
    end
    case (pr_phase)
      mmscp_pkg::PhCommand: begin
        pr_sum = d;
        pr_cmd = d;
        pr_cnt = '0;
        pr_need = '0;
        if (d == mmscp_pkg::CmdServoAngle || d == mmscp_pkg::CmdServoTrim) begin
          pr_need = 2'd2;
          pr_phase = mmscp_pkg::PhPayload;
        end else if (d == mmscp_pkg::CmdMotorSpeed || d == mmscp_pkg::CmdMotorInv ||
                     d == mmscp_pkg::CmdServoInv) begin
          pr_need = 2'd1;
          pr_phase = mmscp_pkg::PhPayload;
        end else begin
          pr_phase = mmscp_pkg::PhIdle;
          r.status = mmscp_pkg::StUnknown;
        end
      end
      mmscp_pkg::PhPayload: begin
        pr_sum = pr_sum ^ d;
        pr_pay[pr_cnt[0]] = d;
        pr_cnt = pr_cnt + 2'd1;
        if (pr_cnt >= pr_need) pr_phase = mmscp_pkg::PhCheck;
      end
      mmscp_pkg::PhCheck: begin
        pr_sum = pr_sum ^ d;
        pr_phase = mmscp_pkg::PhIdle;
        if (pr_sum != '0) begin
          r.status = mmscp_pkg::StBadSum;
        end else begin
          r.status = mmscp_pkg::StApplied;
          case (pr_cmd)
            mmscp_pkg::CmdServoAngle: begin
              v = int'($signed({pr_pay[1], pr_pay[0]}));
              if (pr_servo_inv) v = -v;
              v = v + int'(pr_trim);
              if (v > int'(mmscp_pkg::ServoMax)) v = int'(mmscp_pkg::ServoMax);
              if (v < 0) v = 0;
              r.servo_update = 1'b1;
              r.servo_compare = 11'(int'(mmscp_pkg::ServoBase) + (1000 * v) / 1800);
            end
            mmscp_pkg::CmdMotorSpeed: begin
              v = int'($signed(pr_pay[0]));
              r.motor_forward = ~pr_motor_inv;
              if (v < 0) begin
                r.motor_forward = pr_motor_inv;
                v = -v;
              end
              if (v > int'(mmscp_pkg::MotorMax)) v = int'(mmscp_pkg::MotorMax);
              r.motor_update = 1'b1;
              r.motor_compare = 9'(v * 4);
            end
            mmscp_pkg::CmdMotorInv: pr_motor_inv = (pr_pay[0] != '0);
            mmscp_pkg::CmdServoInv: pr_servo_inv = (pr_pay[0] != '0);
            mmscp_pkg::CmdServoTrim: begin
              v = int'(pr_pay[0]) + 256 * int'(pr_pay[1]);
              if (v > int'(mmscp_pkg::ServoMax)) v = int'(mmscp_pkg::ServoMax);
              pr_trim = 11'(v);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic mmscp_pkg::result_t outcome(input mmscp_pkg::status_e st,
                                                 input logic led, input logic su,
                                                 input logic [mmscp_pkg::ServoW-1:0] sc,
                                                 input logic mu,
                                                 input logic [mmscp_pkg::MotorW-1:0] mc,
                                                 input logic mf);
    mmscp_pkg::result_t r;
    r = '0;
    r.status = st;
    r.led_toggle = led;
    r.servo_update = su;
    r.servo_compare = sc;
    r.motor_update = mu;
    r.motor_compare = mc;
    r.motor_forward = mf;
    return r;
  endfunction

  function automatic probe_t typed(input logic [mmscp_pkg::WordW-1:0] w,
                                   input mmscp_pkg::result_t r);
    return {w, 1'b1, r};
  endfunction

  function automatic probe_t plain(input logic [mmscp_pkg::WordW-1:0] w);
    return {w, 1'b0, mmscp_pkg::result_t'('0)};
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_mismatch($sformatf("status #%0d %s got %0d want %0d", n_results, name, got, want));
  endtask

  task automatic compare_result(input logic [31:0] data);
    mmscp_pkg::result_t got;
    mmscp_pkg::result_t want;
    got = data[$bits(mmscp_pkg::result_t)-1:0];
    if (owed_status_q.size() == 0) begin
      flag_mismatch($sformatf("status 0x%h with no request owed", data));
      return;
    end
    want = owed_status_q.pop_front();
    check_field("status", 32'(got.status), 32'(want.status));
    check_field("led_toggle", 32'(got.led_toggle), 32'(want.led_toggle));
    check_field("servo_update", 32'(got.servo_update), 32'(want.servo_update));
    check_field("servo_compare", 32'(got.servo_compare), 32'(want.servo_compare));
    check_field("motor_update", 32'(got.motor_update), 32'(want.motor_update));
    check_field("motor_compare", 32'(got.motor_compare), 32'(want.motor_compare));
    check_field("motor_forward", 32'(got.motor_forward), 32'(want.motor_forward));
    check_field("pad", 32'(data[31:$bits(mmscp_pkg::result_t)]), 0);
    n_results++;
    case (want.status)
      mmscp_pkg::StMatched: n_matched++;
      mmscp_pkg::StUnknown: n_unknown++;
      mmscp_pkg::StBadSum: n_badsum++;
      mmscp_pkg::StApplied: begin
        if (want.motor_update) n_motor++;
        else if (want.servo_update) n_servo++;
        else n_settings++;
      end
      default: ;
    endcase
  endtask

  // result side: random stall per status, with stretches of none
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(31, 0) == 0) snk_burst = !snk_burst;
      stall = snk_burst ? 0 : $urandom_range(15, 0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      compare_result(m_axis_tdata);
    end
  end

  task automatic send_word(input logic [mmscp_pkg::WordW-1:0] w, input logic has_want,
                           input mmscp_pkg::result_t want);
    int unsigned        gap;
    mmscp_pkg::result_t r;
    if ($urandom_range(31, 0) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(15, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {{(16 - mmscp_pkg::WordW){1'b0}}, w};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = parse_word(w);
    owed_status_q.push_back(has_want ? want : r);
    n_words++;
  endtask

  task automatic write_mask(input logic [mmscp_pkg::ByteW-1:0] mask);
    s_axis_tvalid <= 1'b0;
    while (owed_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_data_i <= mask;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pr_mask = mask;
    n_masks++;
  endtask

  // mostly well-formed frames with random content; some noise, bad sums, cut frames
  task automatic send_frame();
    int unsigned                 kind;
    int unsigned                 need;
    int unsigned                 b;
    logic [mmscp_pkg::ByteW-1:0] addr;
    logic [mmscp_pkg::ByteW-1:0] cmd;
    logic [mmscp_pkg::ByteW-1:0] sum;
    logic [mmscp_pkg::ByteW-1:0] pay;
    kind = $urandom_range(19, 0);
    if (kind == 0) begin
      repeat ($urandom_range(3, 1)) send_word(9'($urandom_range(511, 0)), 1'b0, '0);
      return;
    end
    addr = 8'($urandom_range(255, 0));
    if (pr_mask != '0 && $urandom_range(9, 0) != 0 && (addr & pr_mask) == '0) begin
      do b = $urandom_range(7, 0); while (!pr_mask[b]);
      addr[b] = 1'b1;
    end
    send_word({1'b1, addr}, 1'b0, '0);
    cmd = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 0)) :
                                        8'($urandom_range(14, 10));
    send_word({1'b0, cmd}, 1'b0, '0);
    case (cmd)
      mmscp_pkg::CmdServoAngle, mmscp_pkg::CmdServoTrim: need = 2;
      mmscp_pkg::CmdMotorSpeed, mmscp_pkg::CmdMotorInv, mmscp_pkg::CmdServoInv: need = 1;
      default: need = 0;
    endcase
    if (need == 0) return;
    sum = cmd;
    for (int i = 0; i < need; i++) begin
      case ($urandom_range(7, 0))
        0: pay = 8'h00;
        1: pay = 8'hFF;
        2: pay = ($urandom_range(1, 0) != 0) ? 8'h80 : 8'h7F;
        3: pay = (i == 1) ? (($urandom_range(1, 0) != 0) ? 8'h03 : 8'hFC) : 8'd100;
        default: pay = 8'($urandom_range(255, 0));
      endcase
      sum = sum ^ pay;
      send_word({1'b0, pay}, 1'b0, '0);
    end
    if (kind == 1) return;
    if (kind == 2) sum = sum ^ 8'($urandom_range(255, 1));
    send_word({1'b0, sum}, 1'b0, '0);
  endtask

  initial begin
    logic [mmscp_pkg::ByteW-1:0] masks [5];
    int unsigned                 quota [5];
    int unsigned                 start;
    masks = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h01};
    masks[3] = 8'($urandom_range(254, 2));
    quota = '{400, 150, 450, 450, 466};

    probes.push_back(typed(9'h1FE, outcome(mmscp_pkg::StIgnored, 0, 0, 0, 0, 0, 0)));
    probes.push_back(typed(9'h1FF, outcome(mmscp_pkg::StMatched, 1, 0, 0, 0, 0, 0)));
    probes.push_back(plain(9'h00A));
    probes.push_back(plain(9'h080));
    probes.push_back(typed(9'h08A, outcome(mmscp_pkg::StApplied, 0, 0, 0, 1, 400, 0)));
    probes.push_back(plain(9'h101));
    probes.push_back(plain(9'h00B));
    probes.push_back(plain(9'h0FF));
    probes.push_back(plain(9'h07F));
    probes.push_back(typed(9'h08B, outcome(mmscp_pkg::StApplied, 0, 1, 1999, 0, 0, 0)));
    probes.push_back(plain(9'h101));
    probes.push_back(plain(9'h00D));
    probes.push_back(plain(9'h0FF));
    probes.push_back(typed(9'h0F2, outcome(mmscp_pkg::StApplied, 0, 0, 0, 0, 0, 0)));
    probes.push_back(plain(9'h101));
    probes.push_back(plain(9'h00E));
    probes.push_back(plain(9'h0FF));
    probes.push_back(plain(9'h0FF));
    probes.push_back(typed(9'h00E, outcome(mmscp_pkg::StApplied, 0, 0, 0, 0, 0, 0)));
    // inverted and trimmed to the top, so full positive angle lands at the bottom
    probes.push_back(plain(9'h101));
    probes.push_back(plain(9'h00B));
    probes.push_back(plain(9'h0FF));
    probes.push_back(plain(9'h07F));
    probes.push_back(typed(9'h08B, outcome(mmscp_pkg::StApplied, 0, 1, 1000, 0, 0, 0)));
    probes.push_back(plain(9'h101));
    probes.push_back(plain(9'h00C));
    probes.push_back(plain(9'h001));
    probes.push_back(typed(9'h000, outcome(mmscp_pkg::StBadSum, 0, 0, 0, 0, 0, 0)));
    probes.push_back(plain(9'h101));
    probes.push_back(typed(9'h0FF, outcome(mmscp_pkg::StUnknown, 0, 0, 0, 0, 0, 0)));
    probes.push_back(typed(9'h00A, outcome(mmscp_pkg::StNothing, 0, 0, 0, 0, 0, 0)));
    probes.push_back(plain(9'h101));
    probes.push_back(plain(9'h00A));
    probes.push_back(typed(9'h100, outcome(mmscp_pkg::StIgnored, 0, 0, 0, 0, 0, 0)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) send_word(probes[i].word, probes[i].typed, probes[i].want);

    foreach (masks[p]) begin
      write_mask(masks[p]);
      start = n_words;
      while (n_words - start < quota[p]) send_frame();
    end

    s_axis_tvalid <= 1'b0;
    while (owed_status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d words sent, %0d statuses checked over %0d mask settings",
             n_words, n_results, n_masks + 1);
    $display("matched %0d, motor %0d, servo %0d, flag/trim %0d, bad sum %0d, unknown %0d",
             n_matched, n_motor, n_servo, n_settings, n_badsum, n_unknown);
    if (n_errors == 0) begin
      $display("** multidrop_motor_servo_command_parser: PASSED **");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("** multidrop_motor_servo_command_parser: FAILED **");
    end
    $finish;
  end

endmodule
